[hdl/ansi_color_text_console_assert.svh]
`ifndef ANSI_COLOR_TEXT_CONSOLE_ASSERT_SVH
`define ANSI_COLOR_TEXT_CONSOLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ACTC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("actc assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ACTC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("actc assertion failed");

`endif

[hdl/actc_pkg.sv]
`default_nettype none

package actc_pkg;

    typedef enum logic [1:0] {
        PH_TEXT  = 2'd0,
        PH_NEXT  = 2'd1,
        PH_END   = 2'd2,
        PH_PARSE = 2'd3
    } phase_t;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_MUTED   = 2'd2;

    localparam logic KIND_DRAW  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [7:0] CH_ESC     = 8'h1b;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_NL      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] FINAL_LO   = 8'h40;
    localparam logic [7:0] FINAL_HI   = 8'h7e;
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7e;

    localparam logic [7:0] ATTR_RESET = 8'hf0;
    localparam logic [3:0] TENS_FG    = 4'd3;
    localparam logic [3:0] TENS_BG    = 4'd4;

    localparam logic [7:0] COLUMNS_RESET = 8'd20;
    localparam logic [7:0] ROWS_RESET    = 8'd10;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] col;
        logic [7:0] row;
        logic [6:0] glyph;
        logic [3:0] fg_idx;
        logic [3:0] bg_idx;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'haa0000;
            4'd2:    rgb = 24'h00aa00;
            4'd3:    rgb = 24'haaaa00;
            4'd4:    rgb = 24'h0000aa;
            4'd5:    rgb = 24'haa00aa;
            4'd6:    rgb = 24'h0055aa;
            4'd7:    rgb = 24'haaaaaa;
            4'd8:    rgb = 24'h555555;
            4'd9:    rgb = 24'hff5555;
            4'd10:   rgb = 24'h55ff55;
            4'd11:   rgb = 24'hffff55;
            4'd12:   rgb = 24'h5555ff;
            4'd13:   rgb = 24'hff55ff;
            4'd14:   rgb = 24'h55ffff;
            default: rgb = 24'hffffff;
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

[hdl/actc_core.sv]
`default_nettype none

module actc_core
    import actc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_fire,
    input  wire logic [7:0] char_code,
    output push_t           push
);

    logic [7:0] columns_reg;
    logic [7:0] rows_reg;
    logic       muted_reg;

    phase_t     phase_reg, phase_next;
    logic [3:0] accum_reg, accum_next;
    logic [7:0] attr_reg, attr_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;

    logic       consumed;
    logic       is_digit;
    logic       is_final;
    logic [3:0] digit;

    logic       out_go;
    logic       wrap;
    logic [8:0] row_a;
    logic       clr;
    logic [7:0] col_b;
    logic [7:0] row_b;
    logic       printable;
    logic       draw;
    res_t       clear_res;
    res_t       draw_res;

    assign is_digit = (char_code inside {[CH_ZERO:CH_NINE]});
    assign is_final = (char_code inside {[FINAL_LO:FINAL_HI]});
    assign digit    = 4'(char_code - CH_ZERO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
            muted_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_COLUMNS: columns_reg <= cfg_data;
                CFG_ROWS:    rows_reg    <= cfg_data;
                CFG_MUTED:   muted_reg   <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Escape parser: next phase and consume flag
    always_comb
    begin
        phase_next = phase_reg;
        consumed   = 1'b1;
        case (phase_reg)
            PH_TEXT:
            begin
                if (char_code == CH_ESC)
                    phase_next = PH_NEXT;
                else
                    consumed = 1'b0;
            end
            PH_NEXT:
            begin
                if (char_code == CH_LBRACK)
                    phase_next = PH_PARSE;
                else
                begin
                    phase_next = PH_TEXT;
                    consumed   = 1'b0;
                end
            end
            PH_END:
            begin
                if (char_code == CH_SEMI)
                    phase_next = PH_PARSE;
                else if (is_final)
                    phase_next = PH_TEXT;
            end
            PH_PARSE:
            begin
                if (is_digit)
                begin
                    // accumulator holds 0..9 here; a second digit, or a leading 0, completes the code
                    if (accum_reg != 4'd0 || digit == 4'd0)
                        phase_next = PH_END;
                end
                else if (is_final)
                    phase_next = PH_TEXT;
            end
            default: phase_next = PH_TEXT;
        endcase
    end

    // Parser data: accumulator and color attribute
    always_comb
    begin
        accum_next = accum_reg;
        attr_next  = attr_reg;
        case (phase_reg)
            PH_NEXT:
            begin
                if (char_code == CH_LBRACK)
                    accum_next = 4'd0;
            end
            PH_END:
            begin
                if (char_code == CH_SEMI)
                    accum_next = 4'd0;
            end
            PH_PARSE:
            begin
                if (is_digit)
                begin
                    if (accum_reg == 4'd0)
                    begin
                        accum_next = digit;
                        if (digit == 4'd0)
                            attr_next = ATTR_RESET;
                    end
                    else if (accum_reg == TENS_FG)
                        attr_next = {digit, attr_reg[3:0]};
                    else if (accum_reg == TENS_BG)
                        attr_next = {attr_reg[7:4], digit};
                end
                else if (char_code == CH_SEMI)
                    accum_next = 4'd0;
            end
            default: ;
        endcase
    end

    // Cursor and result generation
    always_comb
    begin
        out_go    = in_fire && !consumed && !muted_reg;
        wrap      = (col_reg >= columns_reg);
        row_a     = {1'b0, row_reg} + {8'd0, wrap};
        clr       = (row_a >= {1'b0, rows_reg});
        col_b     = (wrap || clr) ? 8'd0 : col_reg;
        row_b     = clr ? 8'd0 : row_a[7:0];
        printable = (char_code inside {[PRINT_LO:PRINT_HI]});
        draw      = out_go && printable;

        col_next = col_reg;
        row_next = row_reg;
        if (out_go)
        begin
            if (char_code == CH_NL)
            begin
                row_next = row_b + 8'd1;
                col_next = 8'd0;
            end
            else if (char_code == CH_CR)
            begin
                row_next = row_b;
                col_next = 8'd0;
            end
            else
            begin
                row_next = row_b;
                col_next = col_b + 8'd1;
            end
        end

        clear_res        = '0;
        clear_res.kind   = KIND_CLEAR;
        clear_res.last   = !draw;

        draw_res.kind    = KIND_DRAW;
        draw_res.col     = col_b;
        draw_res.row     = row_b;
        draw_res.glyph   = char_code[6:0];
        draw_res.fg_idx  = attr_reg[7:4];
        draw_res.bg_idx  = attr_reg[3:0];
        draw_res.last    = 1'b1;

        push.count  = {1'b0, out_go && clr} + {1'b0, draw};
        push.first  = (out_go && clr) ? clear_res : draw_res;
        push.second = draw_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
            accum_reg <= 4'd0;
            attr_reg  <= ATTR_RESET;
            col_reg   <= 8'd0;
            row_reg   <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            attr_reg  <= attr_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule

`default_nettype wire

[hdl/actc_outq.sv]
`default_nettype none

module actc_outq
    import actc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  push_t            push,
    input  wire logic        pop,
    output logic             space,
    output logic             head_valid,
    output res_t             head,
    output logic [QLVL_W-1:0] level
);

    res_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0] level_reg, level_next;
    logic [QPTR_W-1:0] wr_ptr_b;

    assign wr_ptr_b = wr_ptr_reg + QPTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        level_next  = level_reg + QLVL_W'(push.count) - QLVL_W'(pop);
    end

    // room for a full two-result transfer
    assign space      = (level_reg <= QLVL_W'(QDEPTH - 2));
    assign head_valid = (level_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign level      = level_reg;

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_b] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

[hdl/ansi_color_text_console.sv]
// A result enters the result queue when its byte is transferred and is offered
// once it reaches the queue head. Throughput: one byte per cycle while the queue
// has room; a byte that clears and draws pushes two results into the 4-entry
// result queue, which drains one per cycle. Input ready drops above two results.
// Reset (rst_n, asynchronous, active low): plain text phase, attribute 0xf0,
// cursor home, 20 columns, 10 rows, unmuted, queue empty.
`default_nettype none

`include "ansi_color_text_console_assert.svh"

module ansi_color_text_console
    import actc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [7:0]       cell_column,
    output logic [7:0]       cell_row,
    output logic [6:0]       glyph,
    output logic [23:0]      fg_rgb,
    output logic [23:0]      bg_rgb,
    output logic             last
);

    logic              in_fire;
    logic              out_fire;
    push_t             push;
    res_t              head;
    logic [QLVL_W-1:0] level;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    actc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .char_code (char_code),
        .push      (push)
    );

    actc_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (out_fire),
        .space      (in_ready),
        .head_valid (out_valid),
        .head       (head),
        .level      (level)
    );

    assign kind        = head.kind;
    assign cell_column = head.col;
    assign cell_row    = head.row;
    assign glyph       = head.glyph;
    assign fg_rgb      = palette_rgb(head.fg_idx);
    assign bg_rgb      = palette_rgb(head.bg_idx);
    assign last        = head.last;

    `ACTC_ASSERT_IMP(a_push_on_transfer, push.count != 2'd0, in_valid && in_ready)
    `ACTC_ASSERT_IMP(a_pair_order, push.count == 2'd2,
        push.first.kind == KIND_CLEAR && !push.first.last &&
        push.second.kind == KIND_DRAW && push.second.last)
    `ACTC_ASSERT_NXT(a_drain, out_valid && out_ready && push.count == 2'd0,
        level == $past(level) - QLVL_W'(1))
    `ACTC_ASSERT_NXT(a_no_overfill, in_valid && in_ready, level <= QLVL_W'(QDEPTH))

endmodule

`default_nettype wire
